@@ hdl/pgr_pkg.sv @@
// Shared types, constants and helpers of the pan gesture recogniser.
`default_nettype none
package pgr_pkg;

    localparam int POS_FRAC_BITS = 4;
    localparam logic [31:0] SLOW_START_MS = 32'd100;
    localparam int DIV_STEPS = 21;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_MIN_TOUCHES = 3'd0;
    localparam logic [2:0] REG_MAX_TOUCHES = 3'd1;
    localparam logic [2:0] REG_MIN_DIST_SQ = 3'd2;
    localparam logic [2:0] REG_MIN_MOTION  = 3'd3;
    localparam logic [2:0] REG_ADJ_FRAMES  = 3'd4;

    // Point state codes on the input
    localparam logic [2:0] PS_DOWN        = 3'd0;
    localparam logic [2:0] PS_UP          = 3'd1;
    localparam logic [2:0] PS_MOTION      = 3'd2;
    localparam logic [2:0] PS_STATIONARY  = 3'd4;
    localparam logic [2:0] PS_INTERRUPTED = 3'd5;

    // Gesture phase codes on the output
    localparam logic [2:0] PH_POSSIBLE   = 3'd0;
    localparam logic [2:0] PH_STARTED    = 3'd1;
    localparam logic [2:0] PH_CONTINUING = 3'd2;
    localparam logic [2:0] PH_FINISHED   = 3'd3;
    localparam logic [2:0] PH_CANCELLED  = 3'd4;

    typedef struct packed {
        logic [2:0]         point_state;
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic [31:0]        time_ms;
        logic [3:0]         touch_count;
        logic               other_lifted;
    } t_in;

    typedef struct packed {
        logic [2:0]         gesture_phase;
        logic signed [19:0] cur_x;
        logic signed [19:0] cur_y;
        logic signed [19:0] prev_x;
        logic signed [19:0] prev_y;
        logic [31:0]        delta_ms;
        logic [31:0]        event_time;
        logic [3:0]         touches;
        logic               last;
    } t_out;

    typedef struct packed {
        logic [3:0]  min_touches;
        logic [3:0]  max_touches;
        logic [15:0] min_distance_sq;
        logic [7:0]  min_motion_events;
        logic [7:0]  adjust_frames;
    } t_cfg;

    // Point state class worked out by the front
    typedef enum logic [5:0] {
        PC_DOWN   = 6'b000001,
        PC_UP     = 6'b000010,
        PC_MOTION = 6'b000100,
        PC_STAT   = 6'b001000,
        PC_INTR   = 6'b010000,
        PC_LEAVE  = 6'b100000
    } t_pclass;

    typedef struct packed {
        t_pclass            pclass;
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic [31:0]        time_ms;
        logic [3:0]         count;
        logic               lifted;
        logic               in_range;
        logic               is_min;
        logic               is_one;
    } t_job;

    // Recogniser state
    typedef enum logic [4:0] {
        PAN_CLEAR    = 5'b00001,
        PAN_POSSIBLE = 5'b00010,
        PAN_STARTED  = 5'b00100,
        PAN_FINISHED = 5'b01000,
        PAN_FAILED   = 5'b10000
    } t_pan;

    // Clamp to 20 bits signed
    function automatic logic signed [19:0] sat20(input logic signed [29:0] v);
        logic signed [19:0] r;
        if (v > 30'sd524287) begin
            r = 20'sd524287;
        end else if (v < -30'sd524288) begin
            r = -20'sd524288;
        end else begin
            r = v[19:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hdl/pan_gesture_recognizer_top.sv @@
// Top level: configuration registers, front queue and recogniser back end.
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_ready   i_in_data  (pgr_pkg::t_in)
//  output    out        o_out_valid / i_out_ready o_out_data (pgr_pkg::t_out)
//  config    in         psel/penable/pwrite       paddr, pwdata, prdata
//
// A frame passes the IDLE, SQX, SQY, PLAN and END steps in the back when it raises no event; each
// event adds SEND, MUL, FIX and EMIT (SEND and EMIT while fewer than two frames are recorded), and
// a slow start adds DIV, which waits for the bit-serial step divider.
// A two-beat queue in the front keeps taking frames while the back works.
// Reset is synchronous and active low; no clearing pass follows it.
// A stalled output holds the back in its emit step; the queue then fills.
`default_nettype none
module pan_gesture_recognizer_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire pgr_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output pgr_pkg::t_out      o_out_data,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    pgr_pkg::t_cfg r_cfg;
    pgr_pkg::t_job job;
    logic          job_valid, job_pop, wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    // Write the registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_touches       <= 4'd1;
            r_cfg.max_touches       <= 4'd1;
            r_cfg.min_distance_sq   <= 16'd225;
            r_cfg.min_motion_events <= 8'd2;
            r_cfg.adjust_frames     <= 8'd10;
        end else if (wr && paddr[1:0] == 2'b00) begin
            case (paddr[4:2])
                pgr_pkg::REG_MIN_TOUCHES: r_cfg.min_touches       <= pwdata[3:0];
                pgr_pkg::REG_MAX_TOUCHES: r_cfg.max_touches       <= pwdata[3:0];
                pgr_pkg::REG_MIN_DIST_SQ: r_cfg.min_distance_sq   <= pwdata[15:0];
                pgr_pkg::REG_MIN_MOTION:  r_cfg.min_motion_events <= pwdata[7:0];
                pgr_pkg::REG_ADJ_FRAMES:  r_cfg.adjust_frames     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read the registers
    always_comb begin
        case (paddr[4:2])
            pgr_pkg::REG_MIN_TOUCHES: prdata = {28'd0, r_cfg.min_touches};
            pgr_pkg::REG_MAX_TOUCHES: prdata = {28'd0, r_cfg.max_touches};
            pgr_pkg::REG_MIN_DIST_SQ: prdata = {16'd0, r_cfg.min_distance_sq};
            pgr_pkg::REG_MIN_MOTION:  prdata = {24'd0, r_cfg.min_motion_events};
            pgr_pkg::REG_ADJ_FRAMES:  prdata = {24'd0, r_cfg.adjust_frames};
            default:                  prdata = 32'd0;
        endcase
    end

    pgr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_data      (i_in_data),
        .i_cfg       (r_cfg),
        .o_job_valid (job_valid),
        .i_job_pop   (job_pop),
        .o_job       (job)
    );

    pgr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (job_valid),
        .o_job_pop   (job_pop),
        .i_job       (job),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_data      (o_out_data)
    );

endmodule
`default_nettype wire

@@ hdl/pgr_front.sv @@
// Front: accepts touch frames, classifies them and queues them for the back.
`default_nettype none
module pgr_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire pgr_pkg::t_in  i_data,
    input  wire pgr_pkg::t_cfg i_cfg,
    output logic               o_job_valid,
    input  wire logic          i_job_pop,
    output pgr_pkg::t_job      o_job
);

    pgr_pkg::t_job r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    pgr_pkg::t_job n_job;
    logic          push, pop;

    assign o_ready     = (r_cnt != 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_mem[r_rp];
    assign push        = i_valid && o_ready;
    assign pop         = i_job_pop && o_job_valid;

    // Classify the beat
    always_comb begin
        case (i_data.point_state)
            pgr_pkg::PS_DOWN:        n_job.pclass = pgr_pkg::PC_DOWN;
            pgr_pkg::PS_UP:          n_job.pclass = pgr_pkg::PC_UP;
            pgr_pkg::PS_MOTION:      n_job.pclass = pgr_pkg::PC_MOTION;
            pgr_pkg::PS_STATIONARY:  n_job.pclass = pgr_pkg::PC_STAT;
            pgr_pkg::PS_INTERRUPTED: n_job.pclass = pgr_pkg::PC_INTR;
            default:                 n_job.pclass = pgr_pkg::PC_LEAVE;
        endcase
        n_job.x        = i_data.pos_x;
        n_job.y        = i_data.pos_y;
        n_job.time_ms  = i_data.time_ms;
        n_job.count    = i_data.touch_count;
        n_job.lifted   = i_data.other_lifted;
        n_job.in_range = (i_data.touch_count >= i_cfg.min_touches) &&
                         (i_data.touch_count <= i_cfg.max_touches);
        n_job.is_min   = (i_data.touch_count == i_cfg.min_touches);
        n_job.is_one   = (i_data.touch_count == 4'd1);
    end

    // Store the queue entry
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= n_job;
        end
    end

    // Advance the pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ hdl/pgr_div.sv @@
// Serial signed-by-unsigned divider for the slow-start step, one bit a cycle.
`default_nettype none
module pgr_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [20:0] i_num,
    input  wire logic [7:0]         i_den,
    output logic                    o_done,
    output logic signed [19:0]      o_quot
);

    logic        r_busy, r_done, r_neg;
    logic [4:0]  r_cnt;
    logic [7:0]  r_rem, r_den;
    logic [20:0] r_quo;
    logic [8:0]  trial, diff;
    logic        ge;
    logic signed [21:0] signed_q;

    assign trial    = {r_rem, r_quo[20]};
    assign diff     = trial - {1'b0, r_den};
    assign ge       = (trial >= {1'b0, r_den});
    assign signed_q = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign o_quot   = pgr_pkg::sat20(30'(signed_q));
    assign o_done   = r_done;

    // Load the operands, then shift the remainder and quotient while busy
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num[20] ? (~i_num + 21'd1) : i_num;
            r_rem <= 8'd0;
            r_den <= i_den;
            r_neg <= i_num[20];
        end else if (r_busy) begin
            r_rem <= ge ? diff[7:0] : trial[7:0];
            r_quo <= {r_quo[19:0], ge};
        end
    end

    // Count the steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(pgr_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/pgr_back.sv @@
// Back: runs the pan recogniser on queued frames and issues event beats.
`default_nettype none
module pgr_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire pgr_pkg::t_cfg i_cfg,
    input  wire logic          i_job_valid,
    output logic               o_job_pop,
    input  wire pgr_pkg::t_job i_job,
    output logic               o_valid,
    input  wire logic          i_ready,
    output pgr_pkg::t_out      o_data
);

    typedef enum logic [9:0] {
        SQ_IDLE = 10'b0000000001,
        SQ_SQX  = 10'b0000000010,
        SQ_SQY  = 10'b0000000100,
        SQ_PLAN = 10'b0000001000,
        SQ_SEND = 10'b0000010000,
        SQ_DIV  = 10'b0000100000,
        SQ_MUL  = 10'b0001000000,
        SQ_FIX  = 10'b0010000000,
        SQ_EMIT = 10'b0100000000,
        SQ_END  = 10'b1000000000
    } t_seq;

    t_seq               r_seq;
    pgr_pkg::t_job      r_job;
    pgr_pkg::t_pan      r_pan, r_nxt_pan;
    logic signed [19:0] r_down_x, r_down_y, r_last_x, r_last_y;
    logic signed [19:0] r_step_x, r_step_y;
    logic [31:0]        r_down_time, r_newest, r_older, r_dt;
    logic [7:0]         r_motion, r_adj_left;
    logic [1:0]         r_hist;
    logic [41:0]        r_sqx, r_sqy;
    logic               r_mid_rec, r_s2_v, r_post_rec, r_clr, r_second;
    logic [2:0]         r_s2_ph, r_phase;
    logic signed [19:0] r_cx, r_cy, r_px, r_py;
    logic signed [28:0] r_prod_x, r_prod_y;
    pgr_pkg::t_out      r_out;
    logic               r_out_valid;

    logic signed [20:0] dx, dy, div_nx, div_ny;
    logic [20:0]        ax, ay;
    logic [42:0]        dist_sq, thr;
    logic               far, slow, div_start, div_done_x, div_done_y, out_free;
    logic [7:0]         mc_inc, left_new;
    logic signed [19:0] quot_x, quot_y;

    assign dx       = {r_job.x[19], r_job.x} - {r_down_x[19], r_down_x};
    assign dy       = {r_job.y[19], r_job.y} - {r_down_y[19], r_down_y};
    assign ax       = dx[20] ? (~dx + 21'd1) : dx;
    assign ay       = dy[20] ? (~dy + 21'd1) : dy;
    assign dist_sq  = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign thr      = 43'({i_cfg.min_distance_sq, (2 * pgr_pkg::POS_FRAC_BITS)'(0)});
    assign far      = (dist_sq >= thr);
    assign mc_inc   = (r_motion == 8'hFF) ? r_motion : r_motion + 8'd1;
    assign slow     = ((r_job.time_ms - r_down_time) > pgr_pkg::SLOW_START_MS);
    assign left_new = (r_adj_left != 8'd0) ? r_adj_left - 8'd1 : 8'd0;
    assign div_nx   = {r_job.x[19], r_job.x} - {r_down_x[19], r_down_x};
    assign div_ny   = {r_job.y[19], r_job.y} - {r_down_y[19], r_down_y};
    assign div_start = r_seq == SQ_SEND && r_hist == 2'd2 && r_phase == pgr_pkg::PH_STARTED
                       && slow && i_cfg.adjust_frames != 8'd0;
    assign out_free  = !r_out_valid || i_ready;
    assign o_job_pop = (r_seq == SQ_IDLE) && i_job_valid;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;

    pgr_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_nx),
        .i_den   (i_cfg.adjust_frames),
        .o_done  (div_done_x),
        .o_quot  (quot_x)
    );

    pgr_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_ny),
        .i_den   (i_cfg.adjust_frames),
        .o_done  (div_done_y),
        .o_quot  (quot_y)
    );

    // Sequence one frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= SQ_IDLE;
            r_pan       <= pgr_pkg::PAN_CLEAR;
            r_down_x    <= '0;
            r_down_y    <= '0;
            r_down_time <= '0;
            r_motion    <= '0;
            r_hist      <= '0;
            r_newest    <= '0;
            r_older     <= '0;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_adj_left  <= '0;
            r_step_x    <= '0;
            r_step_y    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the beat once taken, unless the emit step refills it
            if (r_out_valid && i_ready && r_seq != SQ_EMIT) begin
                r_out_valid <= 1'b0;
            end
            case (r_seq)
                SQ_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job;
                        r_seq <= SQ_SQX;
                    end
                end
                SQ_SQX: begin
                    r_sqx <= ax * ax;
                    r_seq <= SQ_SQY;
                end
                SQ_SQY: begin
                    r_sqy <= ay * ay;
                    r_seq <= SQ_PLAN;
                end
                SQ_PLAN: begin
                    // Work out the sends and state moves of this frame
                    logic pre, s1v, mid, s2v, post, clr;
                    logic [2:0] s1p, s2p;
                    pgr_pkg::t_pan nxt;
                    pre = 1'b0; s1v = 1'b0; mid = 1'b0; s2v = 1'b0; post = 1'b0;
                    clr = 1'b0; s1p = pgr_pkg::PH_CANCELLED;
                    s2p = pgr_pkg::PH_FINISHED; nxt = r_pan;
                    if (r_job.pclass == pgr_pkg::PC_INTR) begin
                        if (r_pan == pgr_pkg::PAN_STARTED || r_pan == pgr_pkg::PAN_POSSIBLE) begin
                            pre = 1'b1;
                            s1v = 1'b1;
                        end
                        nxt = pgr_pkg::PAN_CLEAR;
                        clr = 1'b1;
                    end else begin
                        case (r_pan)
                            pgr_pkg::PAN_CLEAR: begin
                                if (r_job.pclass == pgr_pkg::PC_DOWN ||
                                    r_job.pclass == pgr_pkg::PC_STAT ||
                                    r_job.pclass == pgr_pkg::PC_MOTION) begin
                                    r_down_x    <= r_job.x;
                                    r_down_y    <= r_job.y;
                                    r_down_time <= r_job.time_ms;
                                    r_motion    <= 8'd0;
                                    if (r_job.is_min) begin
                                        nxt = pgr_pkg::PAN_POSSIBLE;
                                        s1v = 1'b1;
                                        s1p = pgr_pkg::PH_POSSIBLE;
                                    end
                                    post = 1'b1;
                                end
                            end
                            pgr_pkg::PAN_POSSIBLE: begin
                                if (r_job.in_range) begin
                                    if (r_job.pclass == pgr_pkg::PC_MOTION) begin
                                        pre = 1'b1;
                                        r_motion <= mc_inc;
                                        if (mc_inc >= i_cfg.min_motion_events && far) begin
                                            nxt = pgr_pkg::PAN_STARTED;
                                            s1v = 1'b1;
                                            s1p = pgr_pkg::PH_STARTED;
                                        end
                                    end else if (r_job.pclass == pgr_pkg::PC_UP) begin
                                        s1v = 1'b1;
                                        if (far) begin
                                            s1p = pgr_pkg::PH_STARTED;
                                            mid = 1'b1;
                                            s2v = 1'b1;
                                        end
                                        nxt = pgr_pkg::PAN_CLEAR;
                                        clr = 1'b1;
                                    end
                                end else begin
                                    s1v = 1'b1;
                                    if (r_job.is_one && r_job.pclass == pgr_pkg::PC_UP) begin
                                        nxt = pgr_pkg::PAN_CLEAR;
                                        clr = 1'b1;
                                    end else begin
                                        nxt = pgr_pkg::PAN_FAILED;
                                    end
                                end
                            end
                            pgr_pkg::PAN_STARTED: begin
                                pre = 1'b1;
                                s1p = pgr_pkg::PH_FINISHED;
                                if (r_job.in_range) begin
                                    if (r_job.pclass == pgr_pkg::PC_MOTION) begin
                                        s1v = 1'b1;
                                        s1p = pgr_pkg::PH_CONTINUING;
                                    end else if (r_job.pclass == pgr_pkg::PC_UP) begin
                                        s1v = 1'b1;
                                        nxt = pgr_pkg::PAN_CLEAR;
                                        clr = 1'b1;
                                    end else if (r_job.pclass == pgr_pkg::PC_STAT) begin
                                        if (r_job.is_min && r_job.lifted) begin
                                            s1v = 1'b1;
                                            nxt = pgr_pkg::PAN_FINISHED;
                                        end
                                    end
                                end else begin
                                    s1v = 1'b1;
                                    if (r_job.is_one && r_job.pclass == pgr_pkg::PC_UP) begin
                                        nxt = pgr_pkg::PAN_CLEAR;
                                        clr = 1'b1;
                                    end else begin
                                        nxt = pgr_pkg::PAN_FINISHED;
                                    end
                                end
                            end
                            default: begin
                                if (r_job.pclass == pgr_pkg::PC_UP) begin
                                    nxt = pgr_pkg::PAN_CLEAR;
                                    clr = 1'b1;
                                end
                            end
                        endcase
                    end
                    if (pre) begin
                        r_older  <= r_newest;
                        r_newest <= r_job.time_ms;
                        r_hist   <= (r_hist == 2'd2) ? r_hist : r_hist + 2'd1;
                    end
                    r_mid_rec  <= mid;
                    r_s2_v     <= s2v;
                    r_s2_ph    <= s2p;
                    r_post_rec <= post;
                    r_clr      <= clr;
                    r_nxt_pan  <= nxt;
                    r_phase    <= s1p;
                    r_second   <= 1'b0;
                    r_seq      <= s1v ? SQ_SEND : SQ_END;
                end
                SQ_SEND: begin
                    // Pick the previous point and the time delta
                    r_cx <= r_job.x;
                    r_cy <= r_job.y;
                    if (r_hist == 2'd2) begin
                        if (r_phase == pgr_pkg::PH_STARTED) begin
                            r_px <= r_down_x;
                            r_py <= r_down_y;
                            r_dt <= r_job.time_ms - r_down_time;
                            if (slow) begin
                                r_adj_left <= i_cfg.adjust_frames;
                                if (i_cfg.adjust_frames == 8'd0) begin
                                    r_step_x <= '0;
                                    r_step_y <= '0;
                                end
                            end else begin
                                r_adj_left <= 8'd0;
                                r_step_x   <= '0;
                                r_step_y   <= '0;
                            end
                        end else begin
                            r_px <= r_last_x;
                            r_py <= r_last_y;
                            r_dt <= r_job.time_ms - r_older;
                        end
                        r_seq <= div_start ? SQ_DIV : SQ_MUL;
                    end else begin
                        r_px  <= r_job.x;
                        r_py  <= r_job.y;
                        r_dt  <= 32'd0;
                        r_seq <= SQ_EMIT;
                    end
                end
                SQ_DIV: begin
                    if (div_done_x && div_done_y) begin
                        r_step_x <= quot_x;
                        r_step_y <= quot_y;
                        r_seq    <= SQ_MUL;
                    end
                end
                SQ_MUL: begin
                    r_adj_left <= left_new;
                    r_prod_x   <= r_step_x * $signed({1'b0, left_new});
                    r_prod_y   <= r_step_y * $signed({1'b0, left_new});
                    r_seq      <= SQ_FIX;
                end
                SQ_FIX: begin
                    // Phase the threshold out of the reported point
                    logic signed [19:0] cx, cy;
                    cx = pgr_pkg::sat20(30'(r_cx) - 30'(r_prod_x));
                    cy = pgr_pkg::sat20(30'(r_cy) - 30'(r_prod_y));
                    r_cx     <= cx;
                    r_cy     <= cy;
                    r_last_x <= cx;
                    r_last_y <= cy;
                    r_seq    <= SQ_EMIT;
                end
                SQ_EMIT: begin
                    if (out_free) begin
                        r_out.gesture_phase <= r_phase;
                        r_out.cur_x         <= r_cx;
                        r_out.cur_y         <= r_cy;
                        r_out.prev_x        <= r_px;
                        r_out.prev_y        <= r_py;
                        r_out.delta_ms      <= r_dt;
                        r_out.event_time    <= r_job.time_ms;
                        r_out.touches       <= r_job.count;
                        r_out.last          <= r_second || !r_s2_v;
                        r_out_valid         <= 1'b1;
                        if (!r_second && r_s2_v) begin
                            if (r_mid_rec) begin
                                r_older  <= r_newest;
                                r_newest <= r_job.time_ms;
                                r_hist   <= (r_hist == 2'd2) ? r_hist : r_hist + 2'd1;
                            end
                            r_second <= 1'b1;
                            r_phase  <= r_s2_ph;
                            r_seq    <= SQ_SEND;
                        end else begin
                            r_seq <= SQ_END;
                        end
                    end
                end
                SQ_END: begin
                    if (r_post_rec) begin
                        r_older  <= r_newest;
                        r_newest <= r_job.time_ms;
                    end
                    if (r_clr) begin
                        r_hist <= 2'd0;
                    end else if (r_post_rec && r_hist != 2'd2) begin
                        r_hist <= r_hist + 2'd1;
                    end
                    r_pan <= r_nxt_pan;
                    r_seq <= SQ_IDLE;
                end
                default: r_seq <= SQ_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
